>>> rtl/core/rvlm_pkg.sv
// rvlm_pkg: shared types and constants for the rms voice level meter
// microcode operation codes, sequencer/datapath control structs, fixed widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rvlm_pkg;

  localparam int BYTE_W  = 8;
  localparam int SQ_W    = 31;  // square of a 16-bit signed sample is at most 2^30
  localparam int RAD_W   = 32;
  localparam int ROOT_W  = 16;
  localparam int VOL_W   = 16;
  localparam int LVL_W   = 8;
  localparam int UPC_W   = 4;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] MAX_VOLUME_RST  = 8'd200;
  localparam logic [CFG_W-1:0] LEVEL_COUNT_RST = 8'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_STEP,
    OP_DIV,
    OP_SAVE_STEP,
    OP_LD_MEAN,
    OP_LD_SQRT,
    OP_SQRT,
    OP_SCALE,
    OP_VOL_ZERO,
    OP_LD_LVL,
    OP_EMIT,
    OP_EMIT_ZERO
  } op_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic fire;  // result goes to the output register this cycle
    logic busy;  // sequencer away from the byte wait step
  } ctl_t;

  // status back to the sequencer
  typedef struct packed {
    logic acc;
    logic last;
    logic stop;
    logic empty;
    logic out_free;
  } stat_t;

endpackage : rvlm_pkg
`default_nettype wire

>>> rtl/core/rvlm_seq.sv
// rvlm_seq: microcoded sequencer, program rom, step counter and loop counter
// drives the datapath through rvlm_pkg::ctl_t
// depends on rvlm_pkg
`timescale 1ns / 1ps
`default_nettype none
module rvlm_seq #(
  parameter int SUM_W = 43
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rvlm_pkg::stat_t stat,
  output rvlm_pkg::ctl_t      ctl
);
  import rvlm_pkg::*;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_LOOP,
    BR_IF_EMPTY,
    BR_JUMP,
    BR_EMIT
  } br_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_DIV,
    LD_SQRT
  } ld_t;

  typedef struct packed {
    op_t              op;
    br_t              br;
    ld_t              ld;
    logic [UPC_W-1:0] tgt;
  } uword_t;

  localparam int LOOP_W = $clog2(SUM_W);
  localparam logic [LOOP_W-1:0] DIV_LAST  = LOOP_W'(SUM_W - 1);
  localparam logic [LOOP_W-1:0] SQRT_LAST = LOOP_W'(ROOT_W - 1);

  localparam logic [UPC_W-1:0] S_WAIT      = 4'd0;
  localparam logic [UPC_W-1:0] S_LD_STEP   = 4'd1;
  localparam logic [UPC_W-1:0] S_STEP_DIV  = 4'd2;
  localparam logic [UPC_W-1:0] S_SAVE_STEP = 4'd3;
  localparam logic [UPC_W-1:0] S_LD_MEAN   = 4'd4;
  localparam logic [UPC_W-1:0] S_MEAN_DIV  = 4'd5;
  localparam logic [UPC_W-1:0] S_LD_SQRT   = 4'd6;
  localparam logic [UPC_W-1:0] S_SQRT      = 4'd7;
  localparam logic [UPC_W-1:0] S_SCALE     = 4'd8;
  localparam logic [UPC_W-1:0] S_VOL_ZERO  = 4'd9;
  localparam logic [UPC_W-1:0] S_LD_LVL    = 4'd10;
  localparam logic [UPC_W-1:0] S_LVL_DIV   = 4'd11;
  localparam logic [UPC_W-1:0] S_EMIT      = 4'd12;
  localparam logic [UPC_W-1:0] S_EMIT_ZERO = 4'd13;

  function automatic uword_t rom(input logic [UPC_W-1:0] a);
    uword_t w;
    unique case (a)
      S_WAIT:      w = '{OP_NONE,      BR_WAIT_IN,  LD_NONE, S_EMIT_ZERO};
      S_LD_STEP:   w = '{OP_LD_STEP,   BR_NEXT,     LD_DIV,  S_WAIT};
      S_STEP_DIV:  w = '{OP_DIV,       BR_LOOP,     LD_NONE, S_WAIT};
      S_SAVE_STEP: w = '{OP_SAVE_STEP, BR_NEXT,     LD_NONE, S_WAIT};
      S_LD_MEAN:   w = '{OP_LD_MEAN,   BR_IF_EMPTY, LD_DIV,  S_VOL_ZERO};
      S_MEAN_DIV:  w = '{OP_DIV,       BR_LOOP,     LD_NONE, S_WAIT};
      S_LD_SQRT:   w = '{OP_LD_SQRT,   BR_NEXT,     LD_SQRT, S_WAIT};
      S_SQRT:      w = '{OP_SQRT,      BR_LOOP,     LD_NONE, S_WAIT};
      S_SCALE:     w = '{OP_SCALE,     BR_JUMP,     LD_NONE, S_LD_LVL};
      S_VOL_ZERO:  w = '{OP_VOL_ZERO,  BR_NEXT,     LD_NONE, S_WAIT};
      S_LD_LVL:    w = '{OP_LD_LVL,    BR_NEXT,     LD_DIV,  S_WAIT};
      S_LVL_DIV:   w = '{OP_DIV,       BR_LOOP,     LD_NONE, S_WAIT};
      S_EMIT:      w = '{OP_EMIT,      BR_EMIT,     LD_NONE, S_WAIT};
      S_EMIT_ZERO: w = '{OP_EMIT_ZERO, BR_EMIT,     LD_NONE, S_WAIT};
      default:     w = '{OP_NONE,      BR_JUMP,     LD_NONE, S_WAIT};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0]  upc_r, upc_nxt;
  logic [LOOP_W-1:0] loop_r, loop_nxt;
  uword_t            uw;
  logic              fire;

  assign uw = rom(upc_r);

  always_comb begin
    upc_nxt = upc_r;
    fire    = 1'b0;
    unique case (uw.br)
      BR_NEXT: upc_nxt = upc_r + 1'b1;
      BR_WAIT_IN: begin
        if (stat.acc) begin
          if (stat.stop) begin
            upc_nxt = uw.tgt;
          end else if (stat.last) begin
            upc_nxt = upc_r + 1'b1;
          end
        end
      end
      BR_LOOP: begin
        if (loop_r == '0) begin
          upc_nxt = upc_r + 1'b1;
        end
      end
      BR_IF_EMPTY: upc_nxt = stat.empty ? uw.tgt : upc_r + 1'b1;
      BR_JUMP:     upc_nxt = uw.tgt;
      BR_EMIT: begin
        if (stat.out_free) begin
          fire    = 1'b1;
          upc_nxt = uw.tgt;
        end
      end
      default: upc_nxt = S_WAIT;
    endcase
  end

  always_comb begin
    loop_nxt = loop_r;
    unique case (uw.ld)
      LD_DIV:  loop_nxt = DIV_LAST;
      LD_SQRT: loop_nxt = SQRT_LAST;
      default: begin
        if (uw.br == BR_LOOP && loop_r != '0) begin
          loop_nxt = loop_r - 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= S_WAIT;
      loop_r <= '0;
    end else begin
      upc_r  <= upc_nxt;
      loop_r <= loop_nxt;
    end
  end

  assign ctl.op   = uw.op;
  assign ctl.fire = fire;
  assign ctl.busy = (upc_r != S_WAIT);

endmodule : rvlm_seq
`default_nettype wire

>>> rtl/core/rvlm_dp.sv
// rvlm_dp: datapath for the level meter
// sample pairing and square accumulation, shared restoring divider, square root, scaling
// depends on rvlm_pkg, driven by rvlm_seq
`timescale 1ns / 1ps
`default_nettype none
module rvlm_dp #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rvlm_pkg::ctl_t                ctl,
  input  wire logic                          acc,
  input  wire logic [rvlm_pkg::BYTE_W-1:0]   data_byte,
  input  wire logic                          stop_capture,
  input  wire logic [rvlm_pkg::CFG_W-1:0]    max_volume,
  input  wire logic [rvlm_pkg::CFG_W-1:0]    level_count,
  output logic                               empty,
  output logic [rvlm_pkg::VOL_W-1:0]         volume,
  output logic [rvlm_pkg::LVL_W-1:0]         level
);
  import rvlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SQ_W + CNT_W;
  localparam int DVS_W = (CNT_W > 16) ? CNT_W : 16;
  localparam int LVLD_W = VOL_W + 1;

  // accumulation
  logic [BYTE_W-1:0] hold_r;
  logic              phase_r;
  logic [SQ_W-1:0]   sq_r;
  logic              sq_vld_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic signed [15:0] sample;
  logic signed [31:0] square;
  logic              take;

  assign take   = acc && !stop_capture;
  assign sample = signed'({data_byte, hold_r});
  assign square = sample * sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      count_r  <= '0;
    end else if (ctl.fire) begin
      phase_r  <= 1'b0;
      sq_vld_r <= 1'b0;
      sum_r    <= '0;
      count_r  <= '0;
    end else begin
      // square is registered, added to the sum in the cycle after its high byte
      if (sq_vld_r) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
      sq_vld_r <= 1'b0;
      if (take) begin
        phase_r <= !phase_r;
        if (phase_r && count_r < CNT_W'(MAX_SAMPLES)) begin
          sq_vld_r <= 1'b1;
          count_r  <= count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !phase_r) begin
      hold_r <= data_byte;
    end
    if (take && phase_r) begin
      sq_r <= square[SQ_W-1:0];
    end
  end

  assign empty = (count_r == '0);

  // divider, square root and scale registers
  logic [SUM_W-1:0]    dvd_r;
  logic [DVS_W-1:0]    dvs_r;
  logic [DVS_W-1:0]    rem_r;
  logic [DVS_W:0]      rem_sh;
  logic                div_ge;
  logic [RAD_W-1:0]    rad_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+1:0]   srem_r;
  logic [ROOT_W+3:0]   srem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                sq_ge;
  logic [LVL_W-1:0]    step_r;
  logic [VOL_W-1:0]    vol_r;
  logic [ROOT_W+4:0]   scaled;
  logic [LVL_W-1:0]    lc_eff;
  logic [LVLD_W-1:0]   lvl_dvd;
  logic [15:0]         step_sh;

  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_r};
  assign srem_sh = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sq_ge   = srem_sh >= trial;
  assign scaled  = (ROOT_W+5)'(root_r) * (ROOT_W+5)'(25);
  assign lc_eff  = (level_count == '0) ? LVL_W'(1) : level_count;
  assign step_sh = {step_r, 8'h00};
  assign lvl_dvd = LVLD_W'(vol_r) + LVLD_W'(step_sh) - LVLD_W'(1);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LD_STEP: begin
        dvd_r <= SUM_W'(max_volume);
        dvs_r <= DVS_W'(lc_eff);
        rem_r <= '0;
      end
      OP_DIV: begin
        rem_r <= div_ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
        dvd_r <= {dvd_r[SUM_W-2:0], div_ge};
      end
      OP_SAVE_STEP: begin
        // step below one clamps to one
        step_r <= (dvd_r == '0) ? LVL_W'(1) : dvd_r[LVL_W-1:0];
      end
      OP_LD_MEAN: begin
        dvd_r <= sum_r;
        dvs_r <= DVS_W'(count_r);
        rem_r <= '0;
      end
      OP_LD_SQRT: begin
        // mean of squares never exceeds 2^30
        rad_r  <= {1'b0, dvd_r[SQ_W-1:0]};
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT: begin
        srem_r <= sq_ge ? (ROOT_W+2)'(srem_sh - trial) : (ROOT_W+2)'(srem_sh);
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      end
      OP_SCALE:    vol_r <= scaled[VOL_W+3:4];
      OP_VOL_ZERO: vol_r <= '0;
      OP_LD_LVL: begin
        // ceiling division as floor of (vol + div - 1) / div
        dvd_r <= SUM_W'(lvl_dvd);
        dvs_r <= DVS_W'(step_sh);
        rem_r <= '0;
      end
      OP_NONE, OP_EMIT, OP_EMIT_ZERO: begin
      end
      default: begin
      end
    endcase
  end

  assign volume = vol_r;
  assign level  = (|dvd_r[SUM_W-1:LVL_W]) ? {LVL_W{1'b1}} : dvd_r[LVL_W-1:0];

endmodule : rvlm_dp
`default_nettype wire

>>> rtl/core/rms_voice_level_meter.sv
// rms_voice_level_meter: top level, config registers, output register, assertions
// instantiates rvlm_seq and rvlm_dp, depends on rvlm_pkg
// one pcm byte accepted per cycle while the sequencer waits at its byte step
// a last byte starts the end-of-buffer program: step division, then mean division, square root
//   and scaling (zero volume with no sample), then level division; bytes taken again after the load
// a stop beat leads straight to the zero result; out_stall delays the load of either
// synchronous active-low reset clears the buffer, output valid and config (200, 5)
`timescale 1ns / 1ps
`default_nettype none
module rms_voice_level_meter #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rvlm_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                           in_last_byte,
  input  wire logic                           in_stop_capture,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rvlm_pkg::VOL_W-1:0]          out_volume,
  output logic [rvlm_pkg::LVL_W-1:0]          out_level,
  input  wire logic                           cfg_we,
  input  wire logic [rvlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rvlm_pkg::CFG_W-1:0]     cfg_wdata
);
  import rvlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SQ_W + CNT_W;

  logic [CFG_W-1:0] max_volume_r;
  logic [CFG_W-1:0] level_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_volume_r  <= MAX_VOLUME_RST;
      level_count_r <= LEVEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_VOLUME:  max_volume_r  <= cfg_wdata;
        CFG_LEVEL_COUNT: level_count_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ctl_t              ctl;
  stat_t             stat;
  logic              in_acc;
  logic              dp_empty;
  logic [VOL_W-1:0]  dp_volume;
  logic [LVL_W-1:0]  dp_level;

  logic              out_valid_r, out_valid_nxt;
  logic [VOL_W-1:0]  out_volume_r;
  logic [LVL_W-1:0]  out_level_r;

  assign in_stall = ctl.busy;
  assign in_acc   = in_valid && !ctl.busy;

  assign stat.acc      = in_acc;
  assign stat.last     = in_last_byte;
  assign stat.stop     = in_stop_capture;
  assign stat.empty    = dp_empty;
  assign stat.out_free = !out_valid_r || !out_stall;

  rvlm_seq #(
    .SUM_W (SUM_W)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  rvlm_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .acc          (in_acc),
    .data_byte    (in_data_byte),
    .stop_capture (in_stop_capture),
    .max_volume   (max_volume_r),
    .level_count  (level_count_r),
    .empty        (dp_empty),
    .volume       (dp_volume),
    .level        (dp_level)
  );

  // output register parts the result beat from the sequencer
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_volume_r <= (ctl.op == OP_EMIT_ZERO) ? '0 : dp_volume;
      out_level_r  <= (ctl.op == OP_EMIT_ZERO) ? '0 : dp_level;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_volume = out_volume_r;
  assign out_level  = out_level_r;

  // a result is only loaded when the output register can take it
  a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting beat");

  // a stop beat goes straight to the zero result
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_stop_capture) |=> (ctl.op == OP_EMIT_ZERO))
    else $error("stop beat did not lead to zero result");

  // the end-of-buffer program holds off further bytes
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte && !in_stop_capture) |=> in_stall)
    else $error("byte accepted after a last byte");

  // scaled volume never exceeds 200 in q8.8
  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_volume_r <= VOL_W'(51200)))
    else $error("volume out of range");

endmodule : rms_voice_level_meter
`default_nettype wire

>>> bench/rvlm_checker.sv
// rvlm_checker: scoreboard for the rms voice level meter
// follows beats on the pcm byte, result and register ports, predicts each reading, compares
// depends on rvlm_pkg
`timescale 1ns / 1ps
module rvlm_checker #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [rvlm_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                           in_last_byte,
  input  wire logic                           in_stop_capture,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [rvlm_pkg::VOL_W-1:0]     out_volume,
  input  wire logic [rvlm_pkg::LVL_W-1:0]     out_level,
  input  wire logic                           cfg_we,
  input  wire logic [rvlm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rvlm_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                  mismatches,
  output int                                  readings_due
);
  import rvlm_pkg::*;

  typedef struct packed {
    logic [VOL_W-1:0] vol;
    logic [LVL_W-1:0] lvl;
  } reading_t;

  reading_t readings_q[$];

  logic [CFG_W-1:0]  span_reg;
  logic [CFG_W-1:0]  parts_reg;
  logic [BYTE_W-1:0] lo_hold;
  logic              hi_next;
  logic [42:0]       sq_acc;
  logic [12:0]       n_samples;

  initial begin
    mismatches   = 0;
    readings_due = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void drop_buffer();
    lo_hold   = '0;
    hi_next   = 1'b0;
    sq_acc    = '0;
    n_samples = '0;
  endfunction

  // floor of the square root, one result bit per pass from the top
  function automatic logic [15:0] int_root(input logic [31:0] v);
    logic [15:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      c = {16'd0, r | (16'd1 << b)};
      if (c * c <= v) r = c[15:0];
    end
    return r;
  endfunction

  function automatic reading_t buffer_reading();
    logic [63:0]      mean;
    logic [63:0]      vol;
    logic [63:0]      step;
    logic [63:0]      dv;
    logic [63:0]      lvl;
    logic [CFG_W-1:0] parts;
    reading_t         rd;
    vol   = '0;
    parts = (parts_reg == '0) ? 8'd1 : parts_reg;
    step  = 64'(span_reg) / 64'(parts);
    if (step == 64'd0) step = 64'd1;
    if (n_samples != '0) begin
      mean = 64'(sq_acc) / 64'(n_samples);
      vol  = {48'd0, int_root(mean[31:0])};
      // rms * 200 / 32768 in q8.8
      vol  = (vol * 64'd25) >> 4;
    end
    dv  = step << 8;
    lvl = (vol + dv - 64'd1) / dv;
    if (lvl > 64'd255) lvl = 64'd255;
    rd.vol = vol[VOL_W-1:0];
    rd.lvl = lvl[LVL_W-1:0];
    return rd;
  endfunction

  always @(posedge clk) begin
    reading_t           got;
    reading_t           want;
    logic signed [15:0] smp;
    logic signed [31:0] sq;
    if (!rst_n) begin
      span_reg  = MAX_VOLUME_RST;
      parts_reg = LEVEL_COUNT_RST;
      drop_buffer();
      readings_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.vol = out_volume;
        got.lvl = out_level;
        if (readings_q.size() == 0) begin
          report_mismatch($sformatf("reading vol=%0d lvl=%0d with none due", got.vol, got.lvl));
        end else begin
          want = readings_q.pop_front();
          if (got.vol != want.vol)
            report_mismatch($sformatf("volume got %0d want %0d", got.vol, want.vol));
          if (got.lvl != want.lvl)
            report_mismatch($sformatf("level got %0d want %0d", got.lvl, want.lvl));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VOLUME:  span_reg = cfg_wdata;
          CFG_LEVEL_COUNT: parts_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_stop_capture) begin
          // stop throws away the partial buffer and reads zero
          drop_buffer();
          readings_q.push_back('0);
        end else begin
          if (!hi_next) begin
            lo_hold = in_data_byte;
            hi_next = 1'b1;
          end else begin
            smp     = {in_data_byte, lo_hold};
            hi_next = 1'b0;
            if (n_samples < 13'(MAX_SAMPLES)) begin
              sq        = smp * smp;
              sq_acc    = sq_acc + {11'd0, sq};
              n_samples = n_samples + 13'd1;
            end
          end
          if (in_last_byte) begin
            readings_q.push_back(buffer_reading());
            drop_buffer();
          end
        end
      end
    end
    readings_due <= readings_q.size();
  end

endmodule

>>> bench/tb_rms_voice_level_meter.sv
// tb_rms_voice_level_meter: stimulus and verdict for the rms voice level meter
// drives byte beats, register writes and output back-pressure; checking lives in rvlm_checker
// depends on rvlm_pkg, rvlm_checker and rms_voice_level_meter
`timescale 1ns / 1ps
module tb_rms_voice_level_meter;
  import rvlm_pkg::*;

  localparam int MAX_SAMPLES  = 4096;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_BEATS  = 60;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              in_stop_capture = 1'b0;
  logic              out_stall = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_stall;
  logic              out_valid;
  logic [VOL_W-1:0]  out_volume;
  logic [LVL_W-1:0]  out_level;
  int                mismatches;
  int                readings_due;
  logic              calm = 1'b0;

  always #6 clk = ~clk;

  rms_voice_level_meter #(.MAX_SAMPLES(MAX_SAMPLES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .in_stop_capture(in_stop_capture),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_volume(out_volume), .out_level(out_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rvlm_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .in_stop_capture(in_stop_capture),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_volume(out_volume), .out_level(out_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .readings_due(readings_due)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  // one beat; valid is left high so back-to-back beats need no extra edge
  task automatic put_beat(input logic [7:0] b, input logic last, input logic stop);
    if (!calm) begin
      while ($urandom_range(0, 99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_last_byte    <= last;
    in_stop_capture <= stop;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_sample(input logic [15:0] s, input logic last);
    put_beat(s[7:0], 1'b0, 1'b0);
    put_beat(s[15:8], last, 1'b0);
  endtask

  // hold off until every reading has come out, then let the pipe drain
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_meter(input logic [7:0] span, input logic [7:0] parts);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_VOLUME;
    cfg_wdata <= span;
    @(posedge clk);
    cfg_index <= CFG_LEVEL_COUNT;
    cfg_wdata <= parts;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // whole buffers with random content; the odd one is cut short by a stop
  task automatic random_buffers(input int budget);
    int          sent;
    int          len;
    int          mode;
    int          cut;
    logic [15:0] fix;
    logic [7:0]  b;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 8) begin
        put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
          6, 7, 8:          len = $urandom_range(17, 64);
          default:          len = $urandom_range(65, 400);
        endcase
        mode = $urandom_range(0, 3);
        fix  = 16'($urandom_range(0, 65535));
        cut  = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: b = 8'($urandom_range(0, 255));
            // small samples, high byte is just the sign
            1: b = i[0] ? {8{fix[15]}} : 8'($urandom_range(0, 255));
            2: b = i[0] ? ($urandom_range(0, 1) ? 8'h80 : 8'h7F)
                        : ($urandom_range(0, 1) ? 8'h00 : 8'hFF);
            default: b = i[0] ? fix[15:8] : fix[7:0];
          endcase
          if (i == cut) put_beat(b, 1'($urandom_range(0, 1)), 1'b1);
          else put_beat(b, i == len - 1, 1'b0);
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] span, input logic [7:0] parts, input logic quiet);
    set_meter(span, parts);
    calm <= quiet;
    @(posedge clk);
    random_buffers(PHASE_BEATS);
    settle(8);
    calm <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone byte, no complete sample
    put_beat(8'h5A, 1'b1, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b1);
    // trailing odd byte is dropped
    send_sample(16'hFFFF, 1'b0);
    put_beat(8'hAA, 1'b1, 1'b0);
    // stop in the middle of a buffer, then a fresh one
    put_beat(8'h12, 1'b0, 1'b0);
    put_beat(8'h34, 1'b0, 1'b0);
    put_beat(8'hAB, 1'b1, 1'b1);
    send_sample(16'h0100, 1'b1);
    put_beat(8'hFF, 1'b0, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle(8);

    run_phase(8'd200, 8'd5, 1'b0);
    run_phase(8'd255, 8'd1, 1'b0);
    run_phase(8'd1, 8'd255, 1'b1);
    run_phase(8'd0, 8'd0, 1'b0);
    run_phase(8'd255, 8'd255, 1'b0);
    run_phase(8'd1, 8'd1, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 20)), 1'b0);

    if (mismatches == 0 && readings_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> rms_voice_level_meter.f
rtl/core/rvlm_pkg.sv
rtl/core/rvlm_seq.sv
rtl/core/rvlm_dp.sv
rtl/core/rms_voice_level_meter.sv
bench/rvlm_checker.sv
bench/tb_rms_voice_level_meter.sv
